[design/urif_pkg.sv]
package urif_pkg;

  localparam int FRAME_W   = 9;
  localparam int BYTE_W    = 8;
  localparam int IDLE_W    = 8;
  localparam int CFG_IDX_W = 1;

  typedef logic [1:0]           mode_t;
  typedef logic [FRAME_W-1:0]   frame_val_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [IDLE_W-1:0]    idle_t;
  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  typedef logic [FRAME_W-1:0]   cfg_data_t;

  localparam mode_t MODE_BYTE = 2'd0;
  localparam mode_t MODE_TICK = 2'd1;
  localparam mode_t MODE_READ = 2'd2;

  localparam cfg_index_t CFG_FRAME_LENGTH_LIMIT = 1'b0;
  localparam cfg_index_t CFG_IDLE_TICK_LIMIT    = 1'b1;

  localparam frame_val_t FRAME_LENGTH_LIMIT_RESET = 9'd220;
  localparam idle_t      IDLE_TICK_LIMIT_RESET    = 8'd1;

  typedef struct packed {
    mode_t      mode;
    byte_t      rx_byte;
    frame_val_t read_index;
  } item_t;

  typedef struct packed {
    logic       frame_done;
    frame_val_t frame_start;
    frame_val_t frame_length;
    byte_t      read_data;
    logic       overrun;
  } result_t;

endpackage

[design/urif_stream_if.sv]
interface urif_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[design/uart_rx_ring_idle_framer_unit.sv]
// channel  | direction | payload                               | transaction
// ---------+-----------+---------------------------------------+--------------------------
// item     | in        | mode, rx_byte, read_index             | valid & ready at clk edge
// result   | out       | frame_done, frame_start, frame_length, | valid & ready at clk edge
//          |           | read_data, overrun                    |
// cfg      | in        | cfg_we, cfg_index, cfg_data           | cfg_we at clk edge
//
// one transaction per cycle sustained while result.ready is high; after its item is taken,
// a result passes through the ring memory's registered read port, then the output register.
// rst is synchronous, active high; the ring memory has no reset and no clearing pass.
// a stalled result holds in the output register while one more item is taken into the
// read stage; item.ready falls only when both stages are full.
module uart_rx_ring_idle_framer_unit #(
  parameter int RING_DEPTH = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  urif_pkg::cfg_index_t cfg_index,
  input  urif_pkg::cfg_data_t  cfg_data,
  urif_stream_if.sink          item,
  urif_stream_if.source        result
);
  import urif_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);
  localparam int LW = (PW > FRAME_W) ? PW : FRAME_W;

  // configuration
  frame_val_t frame_length_limit;
  idle_t      idle_tick_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length_limit <= FRAME_LENGTH_LIMIT_RESET;
      idle_tick_limit    <= IDLE_TICK_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_LENGTH_LIMIT: frame_length_limit <= cfg_data;
        CFG_IDLE_TICK_LIMIT:    idle_tick_limit    <= cfg_data[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  // ring state
  logic [PW-1:0] write_pos, write_pos_next;
  logic [PW-1:0] read_pos, read_pos_next;
  logic [PW-1:0] prev_length, prev_length_next;
  logic [PW-1:0] cur_length, cur_length_next;
  idle_t         idle_count, idle_count_next;

  logic [PW-1:0] wp_inc;
  logic [PW:0]   dist_wide;
  logic [PW-1:0] pend_len;
  logic [PW:0]   rp_sum;
  logic [PW-1:0] rp_adv;
  logic [IDLE_W:0] idle_inc;
  logic          close;
  logic [PW-1:0] rd_addr;

  logic          accept;
  logic          wr_en;
  logic          rd_en;
  result_t       res_next;

  // pipeline
  logic          s1_valid;
  logic          s1_is_read;
  result_t       s1_res;
  byte_t         ram_q;
  logic          s1_adv;
  logic          out_valid;
  result_t       out_res;

  byte_t ring_mem [RING_DEPTH];

  // read index folded into the ring
  if (RING_DEPTH >= (1 << FRAME_W)) begin : g_idx_wide
    assign rd_addr = PW'(item.payload.read_index);
  end else if ((RING_DEPTH & (RING_DEPTH - 1)) == 0) begin : g_idx_pow2
    assign rd_addr = item.payload.read_index[PW-1:0];
  end else begin : g_idx_recip
    localparam int SH = 18;
    localparam int unsigned RECIP = (1 << SH) / RING_DEPTH;
    logic [SH+FRAME_W-1:0] prod;
    logic [FRAME_W-1:0]    quot;
    logic [2*FRAME_W-1:0]  qd;
    logic [FRAME_W:0]      rem;
    // quotient estimate is low by at most one, fixed by one subtract
    assign prod = (SH+FRAME_W)'(item.payload.read_index) * (SH+FRAME_W)'(RECIP);
    assign quot = prod[SH+FRAME_W-1:SH];
    assign qd   = (2*FRAME_W)'(quot) * (2*FRAME_W)'(RING_DEPTH);
    assign rem  = (FRAME_W+1)'(item.payload.read_index) - (FRAME_W+1)'(qd);
    assign rd_addr = (rem >= (FRAME_W+1)'(RING_DEPTH))
                   ? PW'(rem - (FRAME_W+1)'(RING_DEPTH)) : PW'(rem);
  end

  assign accept = item.valid && item.ready;
  assign wr_en  = accept && (item.payload.mode == MODE_BYTE);
  assign rd_en  = accept && (item.payload.mode == MODE_READ);

  assign wp_inc = (write_pos == PW'(RING_DEPTH - 1)) ? '0 : write_pos + PW'(1);

  // distance from read_pos forward to write_pos
  assign dist_wide = (read_pos <= write_pos)
                   ? (PW+1)'(write_pos) - (PW+1)'(read_pos)
                   : (PW+1)'(write_pos) + (PW+1)'(RING_DEPTH) - (PW+1)'(read_pos);
  assign pend_len = dist_wide[PW-1:0];

  assign rp_sum = (PW+1)'(read_pos) + (PW+1)'(pend_len);
  assign rp_adv = (rp_sum >= (PW+1)'(RING_DEPTH))
                ? PW'(rp_sum - (PW+1)'(RING_DEPTH)) : rp_sum[PW-1:0];

  assign idle_inc = (IDLE_W+1)'(idle_count) + (IDLE_W+1)'(1);

  always_comb begin
    write_pos_next   = write_pos;
    read_pos_next    = read_pos;
    prev_length_next = prev_length;
    cur_length_next  = cur_length;
    idle_count_next  = idle_count;
    close            = 1'b0;
    res_next         = '0;
    case (item.payload.mode)
      MODE_BYTE: begin
        write_pos_next   = wp_inc;
        res_next.overrun = (wp_inc == read_pos);
      end
      MODE_TICK: begin
        prev_length_next = cur_length;
        cur_length_next  = pend_len;
        if (LW'(pend_len) > LW'(frame_length_limit)) begin
          idle_count_next = '0;
          close           = 1'b1;
        end else if (pend_len != '0 && pend_len == cur_length) begin
          if (idle_inc > (IDLE_W+1)'(idle_tick_limit)) begin
            idle_count_next = '0;
            close           = 1'b1;
          end else begin
            idle_count_next = idle_inc[IDLE_W-1:0];
          end
        end else begin
          idle_count_next = '0;
        end
        if (close) begin
          res_next.frame_done   = 1'b1;
          res_next.frame_start  = FRAME_W'(read_pos);
          res_next.frame_length = FRAME_W'(pend_len);
          read_pos_next         = rp_adv;
          prev_length_next      = '0;
          cur_length_next       = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos   <= '0;
      read_pos    <= '0;
      prev_length <= '0;
      cur_length  <= '0;
      idle_count  <= '0;
    end else if (accept) begin
      write_pos   <= write_pos_next;
      read_pos    <= read_pos_next;
      prev_length <= prev_length_next;
      cur_length  <= cur_length_next;
      idle_count  <= idle_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[write_pos] <= item.payload.rx_byte;
    end
    if (rd_en) begin
      ram_q <= ring_mem[rd_addr];
    end
  end

  assign s1_adv     = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res     <= res_next;
      s1_is_read <= (item.payload.mode == MODE_READ);
    end
    if (s1_adv) begin
      out_res <= '{s1_res.frame_done, s1_res.frame_start, s1_res.frame_length,
                   s1_is_read ? ram_q : byte_t'(0), s1_res.overrun};
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_res;

`ifndef SYNTH
  a_pos_in_ring: assert property (@(posedge clk) disable iff (rst)
    (PW+1)'(write_pos) < (PW+1)'(RING_DEPTH) && (PW+1)'(read_pos) < (PW+1)'(RING_DEPTH))
    else $error("ring position out of range");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    accept && item.payload.mode == MODE_TICK && close
    |=> cur_length == '0 && prev_length == '0 && read_pos == $past(rp_adv))
    else $error("frame close did not clear lengths or advance read_pos");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> s1_valid && out_valid && !result.ready)
    else $error("input stalled with free pipeline space");
`endif

endmodule
